// ===== rtl/kmsd_pkg.sv =====
`default_nettype none
package kmsd_pkg;

  localparam int unsigned ROW_W   = 3;
  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned HIST_W  = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HIST_W-1:0] SAMPLE_TOP = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'b1;

  localparam logic [CFG_W-1:0] PRESS_RESET   = 8'd224;
  localparam logic [CFG_W-1:0] RELEASE_RESET = 8'd31;

  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [HIST_W-1:0]  hist_t;

  typedef struct packed {
    row_t   row;
    level_t keys;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/kmsd_ram.sv =====
`default_nettype none
module kmsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/key_matrix_shift_debounce.sv =====
`default_nettype none
// Keyboard matrix debouncer. Each input word is one scanned row: a row index
// and active-low column levels. Every key keeps an 8-bit sample history; the
// newest pressed sample enters at the top bit. A key turns pressed when its
// history is at or above press_threshold, released when at or below
// release_threshold, and otherwise holds. One output word per input word
// carries the row index and the row's debounced bitmap (zero and no state
// change for a row index at or above ROWS). Histories and key bits of a row
// share one word of a single-port-write RAM, read at the edge that takes a
// word and written back at the next edge, with forwarding for the same row
// back to back. A result word passes through the compute stage register into
// the output queue, from which it leaves when out_stall is low; the block takes
// one row per cycle, limited only by the three-entry output queue when the
// output stalls.
module key_matrix_shift_debounce #(
  parameter int unsigned ROWS = 6,
  parameter int unsigned COLS = 15
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [kmsd_pkg::ROW_W-1:0]       row_index,
  input  wire logic [kmsd_pkg::LEVEL_W-1:0]     column_levels,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [kmsd_pkg::ROW_W-1:0]       row_out,
  output logic      [kmsd_pkg::LEVEL_W-1:0]     row_keys,
  input  wire logic                             cfg_we,
  input  wire logic [kmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kmsd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int unsigned AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned HW     = kmsd_pkg::HIST_W;
  localparam int unsigned LW     = kmsd_pkg::LEVEL_W;
  localparam int unsigned WORD_W = COLS * (HW + 1);
  localparam int unsigned CMP_W  = 6;

  logic [kmsd_pkg::CFG_W-1:0] press_threshold;
  logic [kmsd_pkg::CFG_W-1:0] release_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold   <= kmsd_pkg::PRESS_RESET;
      release_threshold <= kmsd_pkg::RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kmsd_pkg::CFG_PRESS:   press_threshold   <= cfg_data;
        kmsd_pkg::CFG_RELEASE: release_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  logic           accept;
  logic [CMP_W-1:0] row_wide;
  logic [AW-1:0]  in_addr;
  logic           in_range;

  assign accept   = in_valid && !in_stall;
  assign row_wide = {{(CMP_W - kmsd_pkg::ROW_W){1'b0}}, row_index};
  assign in_addr  = row_wide[AW-1:0];
  assign in_range = row_wide < CMP_W'(ROWS);

  // compute stage
  logic                  s1_valid;
  kmsd_pkg::row_t        s1_row;
  kmsd_pkg::level_t      s1_levels;
  logic [AW-1:0]         s1_addr;
  logic                  s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_row      <= row_index;
      s1_levels   <= column_levels;
      s1_addr     <= in_addr;
      s1_in_range <= in_range;
    end
  end

  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] wr_word;
  logic              ram_we;
  logic [ROWS-1:0]   row_written;
  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  logic [WORD_W-1:0] fwd_word;

  kmsd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_addr),
    .wdata(wr_word),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  assign ram_we = s1_valid && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      fwd_valid <= ram_we;
      if (ram_we) begin
        row_written[s1_addr] <= 1'b1;
      end
    end
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_word <= wr_word;
    end
  end

  logic [WORD_W-1:0]      cur_word;
  logic [COLS-1:0]        new_keys;
  logic [COLS+LW-1:0]     levels_wide;
  logic [COLS+LW-1:0]     keys_wide;
  kmsd_pkg::level_t       s1_keys;

  assign levels_wide = {{COLS{1'b1}}, s1_levels};

  always_comb begin
    kmsd_pkg::hist_t h;
    logic            k;
    if (fwd_valid && fwd_addr == s1_addr) begin
      cur_word = fwd_word;
    end else if (row_written[s1_addr]) begin
      cur_word = ram_rdata;
    end else begin
      cur_word = '0;
    end
    for (int c = 0; c < COLS; c++) begin
      h = cur_word[c*HW +: HW];
      k = cur_word[COLS*HW + c];
      h = (h >> 1) | (levels_wide[c] ? '0 : kmsd_pkg::SAMPLE_TOP);
      if (h >= press_threshold) begin
        k = 1'b1;
      end else if (h <= release_threshold) begin
        k = 1'b0;
      end
      wr_word[c*HW +: HW] = h;
      new_keys[c] = k;
    end
    wr_word[COLS*HW +: COLS] = new_keys;
  end

  assign keys_wide = {{LW{1'b0}}, new_keys};
  assign s1_keys   = s1_in_range ? keys_wide[LW-1:0] : '0;

  // output queue, three entries
  kmsd_pkg::result_t q_mem [3];
  logic [1:0]        q_head;
  logic [1:0]        q_tail;
  logic [1:0]        q_count;
  logic              pop;
  kmsd_pkg::result_t q_out;

  assign out_valid = q_count != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (q_count == 2'd3) || (q_count == 2'd2 && s1_valid);
  assign q_out     = q_mem[q_head];
  assign row_out   = q_out.row;
  assign row_keys  = q_out.keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        q_tail <= (q_tail == 2'd2) ? 2'd0 : q_tail + 2'd1;
      end
      if (pop) begin
        q_head <= (q_head == 2'd2) ? 2'd0 : q_head + 2'd1;
      end
      q_count <= q_count + {1'b0, s1_valid} - {1'b0, pop};
    end
    if (s1_valid) begin
      q_mem[q_tail] <= '{row: s1_row, keys: s1_keys};
    end
  end

endmodule
`default_nettype wire
